### hdl/wrpt_pkg.sv
// ----------------------------------------------------------------------------
// wrpt_pkg
// Shared types and codes for the weighted random pick table: operation and
// result codes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wrpt_pkg;

	// Fixed field widths of the transaction ports
	localparam int MODE_W    = 2;
	localparam int ODDS_W    = 27;
	localparam int DATA_W    = 32;
	localparam int SEED_W    = 27;
	localparam int STATUS_W  = 3;
	localparam int IDX_OUT_W = 6;

	// Operation codes; any code with the high bit set is a draw
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;

	// Result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED   = 3'd0,
		ST_CLEARED = 3'd1,
		ST_WIN     = 3'd2,
		ST_MISS    = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_FULL    = 3'd5,
		ST_BADODDS = 3'd6
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;    // latch the input transaction
		logic    clear;      // empty the table
		logic    div_start;  // load the divider
		logic    div_step;   // one quotient bit
		logic    wr_entry;   // append the new entry
		logic    srch_init;  // set search bounds
		logic    srch_upd;   // narrow bounds from the read data
		logic    pay_rd;     // read the final entry
		logic    res_set;    // result with a plain code
		logic    res_win;    // result with the winner
		status_t res_code;
		logic    out_load;   // move result into output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mode_clear;
		logic mode_add;
		logic odds_zero;
		logic full;
		logic empty;
		logic seed_miss;
		logic div_last;
		logic srch_done;
	} sts_t;

endpackage

### hdl/wrpt_ram.sv
// ----------------------------------------------------------------------------
// wrpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wrpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/wrpt_ctrl.sv
// ----------------------------------------------------------------------------
// wrpt_ctrl
// Sequencer for the pick table: decodes a transaction, runs the divider or
// the binary search, and hands the result to the output register.
// ----------------------------------------------------------------------------
module wrpt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  wrpt_pkg::sts_t  sts,
	output wrpt_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_WRITE,
		S_SRCH,
		S_CMP,
		S_PAYW,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands per state
	always_comb begin
		cmd          = '0;
		cmd.res_code = wrpt_pkg::ST_ADDED;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_DECODE: begin
				if (sts.mode_clear) begin
					cmd.clear    = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_code = wrpt_pkg::ST_CLEARED;
				end else if (sts.mode_add) begin
					if (sts.odds_zero) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = wrpt_pkg::ST_BADODDS;
					end else if (sts.full) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = wrpt_pkg::ST_FULL;
					end else begin
						cmd.div_start = 1'b1;
					end
				end else begin
					if (sts.empty) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = wrpt_pkg::ST_EMPTY;
					end else if (sts.seed_miss) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = wrpt_pkg::ST_MISS;
					end else begin
						cmd.srch_init = 1'b1;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_WRITE: begin
				cmd.wr_entry = 1'b1;
				cmd.res_set  = 1'b1;
				cmd.res_code = wrpt_pkg::ST_ADDED;
			end
			S_SRCH: begin
				// midpoint read otherwise; the RAM address follows the bounds
				cmd.pay_rd = sts.srch_done;
			end
			S_CMP: begin
				cmd.srch_upd = 1'b1;
			end
			S_PAYW: begin
				cmd.res_win = 1'b1;
			end
			S_FINISH: begin
				cmd.out_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (cmd.div_start) begin
						state_q <= S_DIV;
					end else if (cmd.srch_init) begin
						state_q <= S_SRCH;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_FINISH;
				end
				S_SRCH: begin
					if (sts.srch_done) begin
						state_q <= S_PAYW;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SRCH;
				end
				S_PAYW: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/wrpt_datapath.sv
// ----------------------------------------------------------------------------
// wrpt_datapath
// Entry storage, restoring divider for the weight share, binary search over
// the cumulative weights, and the result and output registers.
// ----------------------------------------------------------------------------
module wrpt_datapath #(
	parameter int MAX_ENTRIES   = 64,
	parameter int PAYLOAD_WIDTH = 32,
	parameter int SCALE         = 100000000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [wrpt_pkg::MODE_W-1:0]          mode,
	input  logic [wrpt_pkg::ODDS_W-1:0]          odds,
	input  logic [wrpt_pkg::DATA_W-1:0]          payload,
	input  logic [wrpt_pkg::SEED_W-1:0]          seed,
	input  wrpt_pkg::cmd_t                       cmd,
	output wrpt_pkg::sts_t                       sts,
	output logic [wrpt_pkg::STATUS_W-1:0]        status,
	output logic [wrpt_pkg::IDX_OUT_W-1:0]       winner_index,
	output logic [wrpt_pkg::DATA_W-1:0]          winner_payload
);

	localparam int SHARE_W = $clog2(SCALE + 1);
	localparam int CW_W    = SHARE_W + $clog2(MAX_ENTRIES + 1);
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int DCNT_W  = (SHARE_W > 1) ? $clog2(SHARE_W) : 1;
	localparam int CMP_W   = (CW_W > wrpt_pkg::SEED_W) ? CW_W : wrpt_pkg::SEED_W;
	localparam int REM_W   = wrpt_pkg::ODDS_W + 1;
	localparam logic [SHARE_W-1:0] SCALE_V = SHARE_W'(SCALE);

	// Captured transaction
	logic [wrpt_pkg::MODE_W-1:0] mode_q;
	logic [wrpt_pkg::ODDS_W-1:0] odds_q;
	logic [wrpt_pkg::DATA_W-1:0] payload_q;
	logic [wrpt_pkg::SEED_W-1:0] seed_q;

	// Table bookkeeping
	logic [CNT_W-1:0] count_q;
	logic [CW_W-1:0]  total_q;
	logic [CNT_W-1:0] cnt_m1;

	// Divider
	logic [REM_W-1:0]   rem_q;
	logic [SHARE_W-1:0] dq_q;    // dividend shifting out, quotient shifting in
	logic [DCNT_W-1:0]  dcnt_q;
	logic [REM_W-1:0]   trial;
	logic               trial_ge;

	// Search
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic [IDX_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;
	logic [IDX_W-1:0] rd_addr;
	logic [CMP_W-1:0] seed_ext;
	logic [CMP_W-1:0] cw_ext;
	logic [CMP_W-1:0] total_ext;

	// RAM ports
	logic [CW_W-1:0]          cw_wdata;
	logic [CW_W-1:0]          cw_rdata;
	logic [PAYLOAD_WIDTH-1:0] pay_wdata;
	logic [PAYLOAD_WIDTH-1:0] pay_rdata;

	// Result and output
	wrpt_pkg::status_t                 res_status_q;
	logic [wrpt_pkg::IDX_OUT_W-1:0]    res_idx_q;
	logic [wrpt_pkg::DATA_W-1:0]       res_pay_q;
	logic [wrpt_pkg::STATUS_W-1:0]     status_q;
	logic [wrpt_pkg::IDX_OUT_W-1:0]    winner_index_q;
	logic [wrpt_pkg::DATA_W-1:0]       winner_payload_q;

	assign cnt_m1    = count_q - CNT_W'(1);
	assign trial     = {rem_q[REM_W-2:0], dq_q[SHARE_W-1]};
	assign trial_ge  = (trial >= {1'b0, odds_q});
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[IDX_W:1];
	assign rd_addr   = cmd.pay_rd ? lo_q : mid;
	assign seed_ext  = CMP_W'(seed_q);
	assign cw_ext    = CMP_W'(cw_rdata);
	assign total_ext = CMP_W'(total_q);
	assign cw_wdata  = total_q + CW_W'(dq_q);
	assign pay_wdata = PAYLOAD_WIDTH'(payload_q);

	// Status toward the controller
	always_comb begin
		sts.mode_clear = (mode_q == wrpt_pkg::MODE_CLEAR);
		sts.mode_add   = (mode_q == wrpt_pkg::MODE_ADD);
		sts.odds_zero  = (odds_q == '0);
		sts.full       = (count_q == CNT_W'(MAX_ENTRIES));
		sts.empty      = (count_q == '0);
		sts.seed_miss  = (seed_ext > total_ext);
		sts.div_last   = (dcnt_q == '0);
		sts.srch_done  = (lo_q == hi_q);
	end

	// Entry storage
	wrpt_ram #(
		.WIDTH(CW_W),
		.DEPTH(MAX_ENTRIES)
	) u_cw_ram (
		.clk   (clk),
		.we    (cmd.wr_entry),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (cw_wdata),
		.raddr (rd_addr),
		.rdata (cw_rdata)
	);

	wrpt_ram #(
		.WIDTH(PAYLOAD_WIDTH),
		.DEPTH(MAX_ENTRIES)
	) u_pay_ram (
		.clk   (clk),
		.we    (cmd.wr_entry),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (pay_wdata),
		.raddr (rd_addr),
		.rdata (pay_rdata)
	);

	// Table count and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.wr_entry) begin
			count_q <= count_q + CNT_W'(1);
			total_q <= cw_wdata;
		end
	end

	// Input capture, divider, search and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= mode;
			odds_q    <= odds;
			payload_q <= payload;
			seed_q    <= seed;
		end

		// restoring divide of SCALE by odds, one quotient bit per cycle
		if (cmd.div_start) begin
			rem_q  <= '0;
			dq_q   <= SCALE_V;
			dcnt_q <= DCNT_W'(SHARE_W - 1);
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? (trial - {1'b0, odds_q}) : trial;
			dq_q   <= {dq_q[SHARE_W-2:0], trial_ge};
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end

		// first entry whose cumulative weight covers the seed
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= cnt_m1[IDX_W-1:0];
		end else if (cmd.srch_upd) begin
			if (cw_ext >= seed_ext) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + IDX_W'(1);
			end
		end

		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			res_idx_q    <= '0;
			res_pay_q    <= '0;
		end else if (cmd.res_win) begin
			res_status_q <= wrpt_pkg::ST_WIN;
			res_idx_q    <= wrpt_pkg::IDX_OUT_W'(lo_q);
			res_pay_q    <= wrpt_pkg::DATA_W'(pay_rdata);
		end

		if (cmd.out_load) begin
			status_q         <= res_status_q;
			winner_index_q   <= res_idx_q;
			winner_payload_q <= res_pay_q;
		end
	end

	assign status         = status_q;
	assign winner_index   = winner_index_q;
	assign winner_payload = winner_payload_q;

endmodule

### hdl/weighted_random_pick_table_unit.sv
// Clears, rejected adds, and miss or empty draws set their result at decode; adds run
// the restoring divider, one quotient bit per cycle, then write the entry; other draws
// run a binary search in which each step reads the RAM and then narrows the bounds.
// A new transaction can be accepted the cycle after the previous result enters the
// output register. Reset clears the entry count, running total and output valid;
// the entry RAMs are not cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
// weighted_random_pick_table_unit
// Roulette-wheel pick table: appends weighted entries, clears, and draws the
// first entry whose cumulative weight covers a caller-supplied seed.
// ----------------------------------------------------------------------------
module weighted_random_pick_table_unit #(
	parameter int MAX_ENTRIES   = 64,
	parameter int PAYLOAD_WIDTH = 32,
	parameter int SCALE         = 100000000
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [wrpt_pkg::MODE_W-1:0]       mode,
	input  logic [wrpt_pkg::ODDS_W-1:0]       odds,
	input  logic [wrpt_pkg::DATA_W-1:0]       payload,
	input  logic [wrpt_pkg::SEED_W-1:0]       seed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wrpt_pkg::STATUS_W-1:0]     status,
	output logic [wrpt_pkg::IDX_OUT_W-1:0]    winner_index,
	output logic [wrpt_pkg::DATA_W-1:0]       winner_payload
);

	wrpt_pkg::cmd_t cmd;
	wrpt_pkg::sts_t sts;

	// Sequencer
	wrpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and arithmetic
	wrpt_datapath #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH),
		.SCALE         (SCALE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode           (mode),
		.odds           (odds),
		.payload        (payload),
		.seed           (seed),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.winner_index   (winner_index),
		.winner_payload (winner_payload)
	);

endmodule

### tb/sv/weighted_random_pick_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_pick_table_unit_tb
// Drives clear, add and draw transactions into the pick table and checks every
// result against an in-bench model of the cumulative-weight table. Covers bad
// odds, a full table, zero shares, boundary seeds, idle gaps and a long output
// hold-off.
// ----------------------------------------------------------------------------
module weighted_random_pick_table_unit_tb;

	localparam int MAX_ENTRIES   = 64;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int SCALE         = 100000000;
	localparam logic [35:0] SCALE_W = 36'(SCALE);
	localparam logic [26:0] ODDS_MAX = '1;
	localparam logic [1:0]  MODE_DRAW    = 2'd2;
	localparam logic [1:0]  MODE_DRAW_HI = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 64;
	localparam int HOLD_OFF_LEN = 400;

	typedef struct packed {
		wrpt_pkg::status_t status;
		logic [5:0]        win_index;
		logic [31:0]       win_payload;
	} pick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [wrpt_pkg::MODE_W-1:0] mode = '0;
	logic [wrpt_pkg::ODDS_W-1:0] odds = '0;
	logic [wrpt_pkg::DATA_W-1:0] payload = '0;
	logic [wrpt_pkg::SEED_W-1:0] seed = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [wrpt_pkg::STATUS_W-1:0] status;
	logic [wrpt_pkg::IDX_OUT_W-1:0] winner_index;
	logic [wrpt_pkg::DATA_W-1:0] winner_payload;

	// Model copy of the table
	logic [35:0] cum_sum [MAX_ENTRIES];
	logic [31:0] stored_pay [MAX_ENTRIES];
	int unsigned table_count = 0;

	pick_result_t picks_due[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_cycles = 0;
	int unsigned hold_off_reqs = 0;
	int unsigned hold_off_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned n_win = 0, n_miss = 0, n_empty = 0, n_full = 0, n_bad = 0, n_added = 0;

	weighted_random_pick_table_unit #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH),
		.SCALE        (SCALE)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.odds          (odds),
		.payload       (payload),
		.seed          (seed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.winner_index  (winner_index),
		.winner_payload(winner_payload)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("weighted_random_pick_table_unit test failed");
			$finish;
		end
	end

	// Expected result of one transaction; updates the model table
	function automatic pick_result_t predict_pick(input logic [1:0] m, input logic [26:0] o,
			input logic [31:0] p, input logic [26:0] s);
		pick_result_t r;
		logic [35:0] share;
		logic [35:0] base;
		int unsigned hit;
		bit found;
		r.status = wrpt_pkg::ST_CLEARED;
		r.win_index = '0;
		r.win_payload = '0;
		if (m == wrpt_pkg::MODE_CLEAR) begin
			table_count = 0;
			r.status = wrpt_pkg::ST_CLEARED;
		end else if (m == wrpt_pkg::MODE_ADD) begin
			if (o == '0) begin
				r.status = wrpt_pkg::ST_BADODDS;
			end else if (table_count >= MAX_ENTRIES) begin
				r.status = wrpt_pkg::ST_FULL;
			end else begin
				share = SCALE_W / 36'(o);
				base = (table_count == 0) ? '0 : cum_sum[table_count-1];
				cum_sum[table_count] = base + share;
				stored_pay[table_count] = p;
				table_count++;
				r.status = wrpt_pkg::ST_ADDED;
			end
		end else begin
			// either draw code
			if (table_count == 0) begin
				r.status = wrpt_pkg::ST_EMPTY;
			end else if (36'(s) > cum_sum[table_count-1]) begin
				r.status = wrpt_pkg::ST_MISS;
			end else begin
				found = 1'b0;
				hit = table_count - 1;
				for (int unsigned i = 0; i < table_count; i++) begin
					if (!found && 36'(s) <= cum_sum[i]) begin
						hit = i;
						found = 1'b1;
					end
				end
				r.status = wrpt_pkg::ST_WIN;
				r.win_index = 6'(hit);
				r.win_payload = stored_pay[hit];
			end
		end
		return r;
	endfunction

	// Odds spread over big shares, tiny shares, zero shares and rejects
	function automatic logic [26:0] rand_odds();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3) return '0;
		if (r < 30) return 27'($urandom_range(1, 100));
		if (r < 55) return 27'($urandom_range(1, 100000));
		if (r < 85) return 27'($urandom_range(1, SCALE));
		if (r < 95) return 27'($urandom_range(SCALE - 10, SCALE + 10));
		return 27'($urandom_range(SCALE + 1, ODDS_MAX));
	endfunction

	// Seeds aimed at entry boundaries, the total and beyond
	function automatic logic [26:0] rand_seed();
		logic [35:0] v;
		logic [63:0] wide;
		int unsigned i;
		if (table_count == 0) return 27'($urandom);
		i = $urandom_range(0, table_count - 1);
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = cum_sum[i];
			2: v = cum_sum[i] + 1;
			3: v = cum_sum[table_count-1] + 1;
			4: v = 36'($urandom_range(0, SCALE - 1));
			5: v = 36'(27'($urandom));
			default: begin
				wide = {$urandom, $urandom} % (64'(cum_sum[table_count-1]) + 64'd1);
				v = 36'(wide);
			end
		endcase
		if (v > 36'(ODDS_MAX)) v = 36'(27'($urandom));
		return 27'(v);
	endfunction

	// Send one transaction and log its expected result on acceptance
	task automatic send_request(input logic [1:0] m, input logic [26:0] o,
			input logic [31:0] p, input logic [26:0] s);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		odds <= o;
		payload <= p;
		seed <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		picks_due.push_back(predict_pick(m, o, p, s));
		items_sent++;
	endtask

	task automatic send_draw(input logic [26:0] s);
		send_request(($urandom_range(0, 3) == 0) ? MODE_DRAW_HI : MODE_DRAW,
			27'($urandom), $urandom, s);
	endtask

	// Usually clear first, fill with a few entries (now and then past a full table), then draw against them
	task automatic send_sequence();
		int unsigned n_adds;
		int unsigned n_draws;
		if ($urandom_range(0, 3) != 0)
			send_request(wrpt_pkg::MODE_CLEAR, 27'($urandom), $urandom, 27'($urandom));
		n_adds = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
		n_draws = $urandom_range(1, 6);
		repeat (n_adds) send_request(wrpt_pkg::MODE_ADD, rand_odds(), $urandom, 27'($urandom));
		repeat (n_draws) send_draw(rand_seed());
	endtask

	task automatic send_noise();
		send_request(2'($urandom_range(0, 3)), 27'($urandom), $urandom, 27'($urandom));
	endtask

	// Output side: random stalls, plus a counted hold-off on request
	always @(posedge clk) begin
		if (hold_off_seen != hold_off_reqs) begin
			hold_off_seen <= hold_off_reqs;
			hold_off_cycles <= HOLD_OFF_LEN - 1;
			out_ready <= 1'b0;
		end else if (hold_off_cycles != 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		pick_result_t due;
		if (arst_n && out_valid && out_ready) begin
			if (picks_due.size() == 0) begin
				$error("result with no transaction pending: status %0d", status);
				errors++;
			end else begin
				due = picks_due.pop_front();
				if (status !== due.status) begin
					$error("status mismatch: expected %0d, actual %0d", due.status, status);
					errors++;
				end
				if (winner_index !== due.win_index) begin
					$error("winner_index mismatch: expected %0d, actual %0d",
						due.win_index, winner_index);
					errors++;
				end
				if (winner_payload !== due.win_payload) begin
					$error("winner_payload mismatch: expected 0x%08h, actual 0x%08h",
						due.win_payload, winner_payload);
					errors++;
				end
				case (due.status)
					wrpt_pkg::ST_WIN:     n_win++;
					wrpt_pkg::ST_MISS:    n_miss++;
					wrpt_pkg::ST_EMPTY:   n_empty++;
					wrpt_pkg::ST_FULL:    n_full++;
					wrpt_pkg::ST_BADODDS: n_bad++;
					wrpt_pkg::ST_ADDED:   n_added++;
					default:              ;
				endcase
			end
		end
	end

	// Boundary cases on a tiny hand-built table
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_request(MODE_DRAW, '0, '0, '0);
		send_request(MODE_DRAW_HI, ODDS_MAX, '1, ODDS_MAX);
		send_request(wrpt_pkg::MODE_ADD, '0, 32'h1234_5678, '0);
		send_request(wrpt_pkg::MODE_ADD, 27'd1, 32'h0000_0000, '0);
		send_request(wrpt_pkg::MODE_ADD, ODDS_MAX, 32'hFFFF_FFFF, ODDS_MAX);
		send_request(wrpt_pkg::MODE_ADD, 27'(SCALE), 32'h5A5A_5A5A, '0);
		send_request(wrpt_pkg::MODE_ADD, 27'(SCALE + 1), 32'hA5A5_A5A5, '0);
		send_request(MODE_DRAW, '0, '0, '0);
		send_request(MODE_DRAW, '0, '0, 27'(SCALE));
		send_request(MODE_DRAW, '0, '0, 27'(SCALE + 1));
		send_request(MODE_DRAW, '0, '0, 27'(SCALE + 2));
		send_request(MODE_DRAW, '0, '0, ODDS_MAX);
		send_request(MODE_DRAW_HI, '0, '0, 27'd1);
		// second full share pushes the total past the seed range
		send_request(wrpt_pkg::MODE_ADD, 27'd1, 32'hDEAD_BEEF, '0);
		send_request(MODE_DRAW, '0, '0, ODDS_MAX);
		send_request(MODE_DRAW_HI, '0, '0, 27'(SCALE + 2));
		send_request(wrpt_pkg::MODE_CLEAR, ODDS_MAX, '1, ODDS_MAX);
		send_request(MODE_DRAW, '0, '0, '0);
		send_request(wrpt_pkg::MODE_ADD, '0, '0, '0);
		send_request(wrpt_pkg::MODE_ADD, 27'd3, 32'h0BAD_F00D, '0);
		send_request(MODE_DRAW, '0, '0, 27'd33333333);
		send_request(MODE_DRAW, '0, '0, 27'd33333334);
		send_request(wrpt_pkg::MODE_CLEAR, '0, '0, '0);
	endtask

	// Fill every slot, then probe overflow and rejects
	task automatic test_table_full();
		send_idle_pct = 10;
		recv_stall_pct = 10;
		send_request(wrpt_pkg::MODE_CLEAR, '0, '0, '0);
		repeat (MAX_ENTRIES)
			send_request(wrpt_pkg::MODE_ADD, 27'($urandom_range(1, SCALE)), $urandom, '0);
		send_request(wrpt_pkg::MODE_ADD, 27'd1, $urandom, '0);
		send_request(wrpt_pkg::MODE_ADD, '0, $urandom, '0);
		send_request(MODE_DRAW, '0, '0, '0);
		send_request(MODE_DRAW, '0, '0, 27'(cum_sum[MAX_ENTRIES-1]));
		send_request(MODE_DRAW, '0, '0, 27'(cum_sum[MAX_ENTRIES-2] + 1));
		repeat (4) send_draw(rand_seed());
		send_request(wrpt_pkg::MODE_CLEAR, '0, '0, '0);
	endtask

	task automatic test_random(input int unsigned n_items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned stop_at;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 80) send_sequence();
			else send_noise();
		end
	endtask

	// Long output stall while requests keep coming
	task automatic test_backpressure();
		int unsigned stop_at;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_reqs++;
		stop_at = items_sent + 24;
		while (items_sent < stop_at) send_sequence();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random(220, 0, 0);
		test_random(180, 75, 0);
		test_random(180, 0, 75);
		test_backpressure();
		test_random(220, 34, 34);
		in_valid <= 1'b0;
		while (picks_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d transactions: %0d added, %0d wins, %0d misses", items_sent,
			n_added, n_win, n_miss);
		$display("%0d empty draws, %0d adds to a full table, %0d bad odds, %0d errors",
			n_empty, n_full, n_bad, errors);
		if (errors == 0) begin
			$display("weighted_random_pick_table_unit test passed");
		end else begin
			$display("weighted_random_pick_table_unit test failed");
		end
		$finish;
	end

endmodule
